[rtl/knr_pkg.sv]
// ----------------------------------------------------------------------------
// knr_pkg
// Shared types, sizes, codes and tables of the knock rhythm matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package knr_pkg;

	// Sizes of the interval store, the secret pattern and the ports
	localparam int MAX_KNOCKS    = 20;
	localparam int INTERVAL_BITS = 12;
	localparam int IN_BITS       = 12;
	localparam int PCT_BITS      = 7;
	localparam int PCT_FULL      = 100;
	localparam int IDX_W         = $clog2(MAX_KNOCKS);
	localparam int CNT_W         = $clog2(MAX_KNOCKS + 1);
	localparam int TOTAL_W       = $clog2(MAX_KNOCKS * PCT_FULL + 1);
	localparam int DIVD_W        = INTERVAL_BITS + PCT_BITS;
	localparam int STEP_W        = $clog2(PCT_BITS);
	localparam int SEEN_W        = 5;
	localparam int DEV_W         = 11;
	localparam int SEEN_MAX      = (1 << SEEN_W) - 1;
	localparam int DEV_MAX       = (1 << DEV_W) - 1;
	localparam int CFG_IDX_W     = 2;
	localparam int SAT_W         = (IN_BITS > INTERVAL_BITS) ? IN_BITS : INTERVAL_BITS;
	localparam int INTERVAL_MAX  = (1 << INTERVAL_BITS) - 1;

	// Result codes
	typedef enum logic [1:0] {
		VERDICT_ACCEPT      = 2'd0,
		VERDICT_SINGLE_OFF  = 2'd1,
		VERDICT_AVERAGE_OFF = 2'd2,
		VERDICT_STORED      = 2'd3
	} verdict_t;

	// Input word action codes
	localparam logic ACT_RECORD   = 1'b0;
	localparam logic ACT_EVALUATE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SINGLE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE = CFG_IDX_W'(1);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV,
		ST_FINISH
	} state_t;

	// Divider request and response
	typedef struct packed {
		logic                     start;
		logic [DIVD_W-1:0]        dividend;
		logic [INTERVAL_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [PCT_BITS-1:0] quotient;
	} div_rsp_t;

	// Secret pattern value of an entry never programmed since reset
	function automatic logic [PCT_BITS-1:0] secret_init(input logic [IDX_W-1:0] idx);
		logic [PCT_BITS-1:0] val;
		case (int'(idx))
			0:       val = PCT_BITS'(50);
			1:       val = PCT_BITS'(25);
			2:       val = PCT_BITS'(25);
			3:       val = PCT_BITS'(50);
			4:       val = PCT_BITS'(100);
			5:       val = PCT_BITS'(50);
			default: val = '0;
		endcase
		return val;
	endfunction

	// Clamp an incoming interval to the stored width
	function automatic logic [INTERVAL_BITS-1:0] sat_interval(input logic [IN_BITS-1:0] v);
		logic [SAT_W-1:0] wide;
		wide = SAT_W'(v);
		if (wide > SAT_W'(INTERVAL_MAX)) begin
			return '1;
		end
		return INTERVAL_BITS'(wide);
	endfunction

endpackage

`default_nettype wire

[rtl/knr_ram.sv]
// ----------------------------------------------------------------------------
// knr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module knr_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/knr_div.sv]
// ----------------------------------------------------------------------------
// knr_div
// Restoring divider, one quotient bit per cycle, for a quotient that is
// known to fit in PCT_BITS bits.
// ----------------------------------------------------------------------------
`default_nettype none

module knr_div
	import knr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [DIVD_W-1:0]   rem_q;
	logic [DIVD_W-1:0]   dsh_q;
	logic [PCT_BITS-1:0] quo_q;
	logic                fits;

	assign fits = (rem_q >= dsh_q);

	// Step counter and handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(PCT_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	// Subtract the shifted divisor and shift in one quotient bit
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dsh_q <= DIVD_W'(req.divisor) << (PCT_BITS - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[PCT_BITS-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

[rtl/knock_rhythm_matcher.sv]
// ----------------------------------------------------------------------------
// knock_rhythm_matcher
// Record word: accepted while idle, no result; the block stays ready for the next word.
// Evaluate word: walks all MAX_KNOCKS entries in turn, then gives one result; each entry
// takes one RAM read (ST_READ), one load (ST_LOAD) and a run of the bit-serial divider (ST_DIV).
// One evaluate is in flight at a time; a record word may enter while a result waits.
// Reset: thresholds 25 and 15, interval store empty, secret pattern back to its default.
// ----------------------------------------------------------------------------
`default_nettype none

module knock_rhythm_matcher
	import knr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input words
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 action,
	input  wire logic [IN_BITS-1:0]   interval_ms,
	input  wire logic                 program_mode,
	// result words
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                verdict,
	output logic [SEEN_W-1:0]         knocks_seen,
	output logic [DEV_W-1:0]          total_deviation,
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [PCT_BITS-1:0]  cfg_data
);

	localparam int THR_W   = PCT_BITS + 1 + CNT_W;
	localparam int CMP_W   = (THR_W > TOTAL_W) ? THR_W : TOTAL_W;
	localparam int SEENC_W = (CNT_W > SEEN_W) ? CNT_W : SEEN_W;
	localparam int DEVC_W  = (TOTAL_W > DEV_W) ? TOTAL_W : DEV_W;

	state_t                   state_q, state_d;
	logic [PCT_BITS-1:0]      single_q, avg_q;
	logic [CNT_W-1:0]         rec_cnt_q, seen_q, scnt_q;
	logic [INTERVAL_BITS-1:0] longest_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     program_q;
	logic                     single_off_q;
	logic [TOTAL_W-1:0]       total_q;
	logic [PCT_BITS-1:0]      sec_q;
	logic                     live_s1, svld_s1;
	logic [MAX_KNOCKS-1:0]    secret_vld_q;

	logic                     out_valid_q;
	verdict_t                 verdict_q;
	logic [SEEN_W-1:0]        seen_out_q;
	logic [DEV_W-1:0]         dev_out_q;

	logic                     in_fire, rec_fire, eval_fire, store_free;
	logic                     last_entry, fin_load;
	logic [INTERVAL_BITS-1:0] iv_sat, iv_rd, iv_eff;
	logic [PCT_BITS-1:0]      sec_rd, sec_eff, quot_eff, diff;
	logic                     sec_we;
	logic [THR_W-1:0]         thr;
	verdict_t                 verdict_d;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign rec_fire  = in_fire && (action == ACT_RECORD);
	assign eval_fire = in_fire && (action == ACT_EVALUATE);
	assign store_free = (rec_cnt_q < CNT_W'(MAX_KNOCKS));
	assign iv_sat    = sat_interval(interval_ms);
	assign last_entry = (idx_q == IDX_W'(MAX_KNOCKS - 1));
	assign fin_load  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// Interval store: written on record while not full, read during the walk
	knr_ram #(
		.DEPTH (MAX_KNOCKS),
		.WIDTH (INTERVAL_BITS)
	) u_interval_ram (
		.clk   (clk),
		.we    (rec_fire && store_free),
		.waddr (rec_cnt_q[IDX_W-1:0]),
		.wdata (iv_sat),
		.raddr (idx_q),
		.rdata (iv_rd)
	);

	// Secret pattern: rewritten entry by entry in program mode
	assign sec_we = (state_q == ST_DIV) && div_rsp.done && program_q;

	knr_ram #(
		.DEPTH (MAX_KNOCKS),
		.WIDTH (PCT_BITS)
	) u_secret_ram (
		.clk   (clk),
		.we    (sec_we),
		.waddr (idx_q),
		.wdata (quot_eff),
		.raddr (idx_q),
		.rdata (sec_rd)
	);

	// Entries past the fill count read as zero, unprogrammed secrets as default
	assign iv_eff  = live_s1 ? iv_rd : '0;
	assign sec_eff = svld_s1 ? sec_rd : secret_init(idx_q);

	// Scale interval * 100 by the longest interval
	assign div_req.start    = (state_q == ST_LOAD);
	assign div_req.dividend = DIVD_W'(iv_eff) * DIVD_W'(PCT_FULL);
	assign div_req.divisor  = longest_q;

	knr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign quot_eff = (longest_q == '0) ? '0 : div_rsp.quotient;
	assign diff     = (quot_eff > sec_q) ? (quot_eff - sec_q) : (sec_q - quot_eff);

	// Final verdict: floor(total / count) > avg  <=>  total >= (avg + 1) * count
	assign thr = THR_W'(THR_W'(avg_q) + THR_W'(1)) * THR_W'(scnt_q);

	always_comb begin
		if (program_q) begin
			verdict_d = VERDICT_STORED;
		end else if (single_off_q) begin
			verdict_d = VERDICT_SINGLE_OFF;
		end else if (scnt_q == '0) begin
			verdict_d = VERDICT_AVERAGE_OFF;
		end else if (CMP_W'(total_q) >= CMP_W'(thr)) begin
			verdict_d = VERDICT_AVERAGE_OFF;
		end else begin
			verdict_d = VERDICT_ACCEPT;
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (eval_fire) begin
					state_d = ST_READ;
				end
			end
			ST_READ:  state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_DIV;
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = last_entry ? ST_FINISH : ST_READ;
				end
			end
			ST_FINISH: begin
				if (fin_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Thresholds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_q <= PCT_BITS'(25);
			avg_q    <= PCT_BITS'(15);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SINGLE:  single_q <= cfg_data;
				REG_AVERAGE: avg_q    <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Fill count, longest interval and knock count; drop all after evaluate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_cnt_q <= '0;
			seen_q    <= '0;
			longest_q <= '0;
		end else if (fin_load) begin
			rec_cnt_q <= '0;
			seen_q    <= '0;
			longest_q <= '0;
		end else if (rec_fire && store_free) begin
			rec_cnt_q <= rec_cnt_q + CNT_W'(1);
			if (iv_sat != '0) begin
				seen_q <= seen_q + CNT_W'(1);
			end
			if (iv_sat > longest_q) begin
				longest_q <= iv_sat;
			end
		end
	end

	// Secret entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_vld_q <= '0;
		end else if (sec_we) begin
			secret_vld_q[idx_q] <= 1'b1;
		end
	end

	// Walk control: entry index, mode, flags and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			program_q    <= 1'b0;
			single_off_q <= 1'b0;
			total_q      <= '0;
			scnt_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (eval_fire) begin
						idx_q        <= '0;
						program_q    <= program_mode;
						single_off_q <= 1'b0;
						total_q      <= '0;
						scnt_q       <= '0;
					end
				end
				ST_LOAD: begin
					if (sec_eff != '0) begin
						scnt_q <= scnt_q + CNT_W'(1);
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (!program_q && !single_off_q) begin
							if (diff > single_q) begin
								single_off_q <= 1'b1;
							end else begin
								total_q <= total_q + TOTAL_W'(diff);
							end
						end
						if (!last_entry) begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Read-side pipeline: entry liveness and secret validity, then secret value
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			live_s1 <= (CNT_W'(idx_q) < rec_cnt_q);
			svld_s1 <= secret_vld_q[idx_q];
		end
		if (state_q == ST_LOAD) begin
			sec_q <= sec_eff;
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			verdict_q <= verdict_d;
			if (SEENC_W'(seen_q) > SEENC_W'(SEEN_MAX)) begin
				seen_out_q <= SEEN_W'(SEEN_MAX);
			end else begin
				seen_out_q <= SEEN_W'(seen_q);
			end
			if (DEVC_W'(total_q) > DEVC_W'(DEV_MAX)) begin
				dev_out_q <= DEV_W'(DEV_MAX);
			end else begin
				dev_out_q <= DEV_W'(total_q);
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign verdict         = verdict_q;
	assign knocks_seen     = seen_out_q;
	assign total_deviation = dev_out_q;

endmodule

`default_nettype wire

[rtl/knr_check.sv]
// ----------------------------------------------------------------------------
// knr_check
// Port-level checks of the knock rhythm matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module knr_check
	import knr_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 action,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [1:0]           verdict,
	input wire logic [SEEN_W-1:0]    knocks_seen,
	input wire logic [DEV_W-1:0]     total_deviation
);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict)
			&& $stable(knocks_seen) && $stable(total_deviation))
		else $error("result word changed while stalled");

	// Programming reports no deviation
	a_store_dev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict == VERDICT_STORED) |-> (total_deviation == '0))
		else $error("stored verdict with non-zero deviation");

	// Evaluate occupies the block
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == ACT_EVALUATE) |=> !in_ready)
		else $error("input ready right after evaluate");

	// Record words never produce a result
	a_rec_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == ACT_RECORD) && !out_valid |=> !out_valid)
		else $error("result after a record word");

endmodule

bind knock_rhythm_matcher knr_check u_knr_check (.*);

`default_nettype wire
